FILE: design/linear_probe_hash_key_table_top_assert.svh
// assertion macros for the key table
`ifndef LINEAR_PROBE_HASH_KEY_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_KEY_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LPHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lpht_pkg.sv
`default_nettype none

package lpht_pkg;

    localparam int SLOTS    = 64;
    localparam int AW       = $clog2(SLOTS);
    localparam int SIZE_W   = AW + 1;
    localparam int CFG_W    = 7;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = 16;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;
    localparam int HASH_MOD = 100;
    localparam int REM_W    = 7;

    // key mod 100: fold the bytes by 256^k mod 100, then a reciprocal multiply
    localparam int FOLD_W     = 15;
    localparam int QUO_W      = 9;
    localparam int PROD_W     = 2 * FOLD_W;
    localparam int FOLD_W1    = 256 % HASH_MOD;
    localparam int FOLD_W2    = (2 ** 16) % HASH_MOD;
    localparam int FOLD_W3    = (2 ** 24) % HASH_MOD;
    localparam int HASH_SHIFT = 21;
    localparam int HASH_RECIP = (2 ** HASH_SHIFT + HASH_MOD - 1) / HASH_MOD;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_NEW    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd4;

    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

endpackage

`default_nettype wire

FILE: design/linear_probe_hash_key_table_top.sv
`default_nettype none
// channel   valid        stall        payload
// ------    -----------  -----------  ----------------------------------
// in        i_in_valid   o_in_stall   i_func, i_key
// out       o_out_valid  i_out_stall  o_status, o_slot, o_items_at_key
// cfg       i_cfg_we     (none)       i_cfg_data (table_size)
//
// one item at a time; o_in_stall stays high from acceptance until the result moves to the output register
// query: scans up to n slots from slot zero, n = effective table size (one slot read per cycle)
// insert: key mod 100 (HASH_A, HASH_Q, HASH_R), mod n over the 7 hash bits, then probing of up to n slots
// the slot memory has one registered read port, which paces the scan
// reset is synchronous: busy flags clear and table_size returns to 64 at once, no clearing pass
// a held result in the output register does not block the next item from entering

`include "linear_probe_hash_key_table_top_assert.svh"

module linear_probe_hash_key_table_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // item input
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_func,
    input  wire logic [lpht_pkg::KEY_W-1:0]     i_key,
    // result output
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [lpht_pkg::STATUS_W-1:0]       o_status,
    output logic [lpht_pkg::SLOT_W-1:0]         o_slot,
    output logic [lpht_pkg::CNT_W-1:0]          o_items_at_key,
    // table_size register
    input  wire logic                           i_cfg_we,
    input  wire logic [lpht_pkg::CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH_A,
        S_HASH_Q,
        S_HASH_R,
        S_HASH_B,
        S_SCAN,
        S_DONE
    } t_state;

    localparam int MEM_W = lpht_pkg::KEY_W + lpht_pkg::CNT_W;

    t_state r_state;

    // configuration and item context
    logic [lpht_pkg::CFG_W-1:0]   r_table_size;
    logic [lpht_pkg::SIZE_W-1:0]  r_size;
    logic                         r_func;
    logic [lpht_pkg::KEY_W-1:0]   r_key;

    // hash unit: folded key, quotient by 100, then mod n one bit per cycle
    logic [lpht_pkg::FOLD_W-1:0]  r_fold;
    logic [lpht_pkg::QUO_W-1:0]   r_quo;
    logic [lpht_pkg::REM_W-1:0]   r_rem;
    logic [lpht_pkg::REM_W-1:0]   r_hash;
    logic [2:0]                   r_bit;

    // scan: issue side and evaluate side
    logic [lpht_pkg::AW-1:0]      r_addr;
    logic [lpht_pkg::SIZE_W-1:0]  r_left;
    logic                         r_ev_v;
    logic                         r_ev_last;
    logic                         r_ev_busy;
    logic [lpht_pkg::AW-1:0]      r_ev_addr;

    // slot state: busy flags in flops, key and count in memory
    logic [lpht_pkg::SLOTS-1:0]   r_busy;
    logic [MEM_W-1:0]             r_mem [lpht_pkg::SLOTS];
    logic [MEM_W-1:0]             r_rd;

    // finished result waiting for the output register
    logic [lpht_pkg::STATUS_W-1:0] r_res_status;
    logic [lpht_pkg::AW-1:0]       r_res_slot;
    logic [lpht_pkg::CNT_W-1:0]    r_res_cnt;

    // output register
    logic                          r_out_v;
    logic [lpht_pkg::STATUS_W-1:0] r_out_status;
    logic [lpht_pkg::SLOT_W-1:0]   r_out_slot;
    logic [lpht_pkg::CNT_W-1:0]    r_out_cnt;

    logic                          in_acc;
    logic                          out_free;
    logic [lpht_pkg::SIZE_W-1:0]   eff_size;

    logic [lpht_pkg::FOLD_W-1:0]   fold_sum;
    logic [lpht_pkg::PROD_W-1:0]   quo_prod;
    logic [lpht_pkg::FOLD_W-1:0]   hash_rem;

    logic                          h_bit;
    logic [lpht_pkg::REM_W:0]      h_div;
    logic [lpht_pkg::REM_W:0]      h_trial;
    logic [lpht_pkg::REM_W:0]      h_next;

    logic [lpht_pkg::SIZE_W-1:0]   addr_inc;
    logic [lpht_pkg::AW-1:0]       n_addr;
    logic                          rd_en;

    logic [lpht_pkg::KEY_W-1:0]    ev_key;
    logic [lpht_pkg::CNT_W-1:0]    ev_cnt;
    logic                          key_eq;
    logic                          ev_hit;
    logic [lpht_pkg::CNT_W-1:0]    new_cnt;
    logic                          wr_en;

    assign o_in_stall     = (r_state != S_IDLE);
    assign in_acc         = i_in_valid && !o_in_stall;
    assign out_free       = !r_out_v || !i_out_stall;

    assign o_out_valid    = r_out_v;
    assign o_status       = r_out_status;
    assign o_slot         = r_out_slot;
    assign o_items_at_key = r_out_cnt;

    // table_size 0 acts as 1, anything above the slot count as the slot count
    always_comb begin
        if (r_table_size == '0) begin
            eff_size = lpht_pkg::SIZE_W'(1);
        end else if (r_table_size > lpht_pkg::CFG_W'(lpht_pkg::SLOTS)) begin
            eff_size = lpht_pkg::SIZE_W'(lpht_pkg::SLOTS);
        end else begin
            eff_size = lpht_pkg::SIZE_W'(r_table_size);
        end
    end

    // key mod 100: byte fold keeps the residue, below 27796
    assign fold_sum = lpht_pkg::FOLD_W'(r_key[7:0])
                    + lpht_pkg::FOLD_W'(r_key[15:8]) * lpht_pkg::FOLD_W'(lpht_pkg::FOLD_W1)
                    + lpht_pkg::FOLD_W'(r_key[23:16]) * lpht_pkg::FOLD_W'(lpht_pkg::FOLD_W2)
                    + lpht_pkg::FOLD_W'(r_key[31:24]) * lpht_pkg::FOLD_W'(lpht_pkg::FOLD_W3);
    // reciprocal multiply gives the exact quotient over the folded range
    assign quo_prod = lpht_pkg::PROD_W'(r_fold) * lpht_pkg::PROD_W'(lpht_pkg::HASH_RECIP);
    assign hash_rem = r_fold - lpht_pkg::FOLD_W'(r_quo) * lpht_pkg::FOLD_W'(lpht_pkg::HASH_MOD);

    // restoring remainder step for mod n
    always_comb begin
        h_bit   = r_hash[r_bit];
        h_div   = (lpht_pkg::REM_W + 1)'(r_size);
        h_trial = {r_rem, h_bit};
        h_next  = (h_trial >= h_div) ? (h_trial - h_div) : h_trial;
    end

    // probe address wraps at the effective size
    assign addr_inc = {1'b0, r_addr} + lpht_pkg::SIZE_W'(1);
    assign n_addr   = (addr_inc == r_size) ? '0 : addr_inc[lpht_pkg::AW-1:0];
    assign rd_en    = (r_state == S_SCAN) && (r_left != '0);

    // evaluate the slot read issued in the previous cycle; count of a free slot reads as zero
    assign ev_key  = r_rd[MEM_W-1:lpht_pkg::CNT_W];
    assign ev_cnt  = r_ev_busy ? r_rd[lpht_pkg::CNT_W-1:0] : '0;
    assign key_eq  = (ev_key == r_key);
    assign ev_hit  = (r_func == lpht_pkg::FUNC_QUERY) ? (r_ev_busy && key_eq)
                                                      : (!r_ev_busy || key_eq);
    assign new_cnt = (ev_cnt == lpht_pkg::COUNT_MAX) ? ev_cnt
                                                     : (ev_cnt + lpht_pkg::CNT_W'(1));
    assign wr_en   = (r_state == S_SCAN) && r_ev_v && ev_hit
                     && (r_func == lpht_pkg::FUNC_INSERT);

    // slot memory: one read, one write per cycle
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_mem[r_addr];
        end
        if (wr_en) begin
            r_mem[r_ev_addr] <= {r_key, new_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_table_size <= lpht_pkg::SIZE_RESET;
            r_busy       <= '0;
            r_out_v      <= 1'b0;
            r_ev_v       <= 1'b0;
            r_left       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_table_size <= i_cfg_data;
            end

            // output register drains independently of the engine
            if (r_state == S_DONE && out_free) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_func <= i_func;
                        r_key  <= i_key;
                        r_size <= eff_size;
                        r_ev_v <= 1'b0;
                        if (i_func == lpht_pkg::FUNC_QUERY) begin
                            // query scans from slot zero
                            r_addr  <= '0;
                            r_left  <= eff_size;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_HASH_A;
                        end
                    end
                end

                S_HASH_A: begin
                    r_fold  <= fold_sum;
                    r_state <= S_HASH_Q;
                end

                S_HASH_Q: begin
                    r_quo   <= quo_prod[lpht_pkg::HASH_SHIFT +: lpht_pkg::QUO_W];
                    r_state <= S_HASH_R;
                end

                S_HASH_R: begin
                    r_hash  <= hash_rem[lpht_pkg::REM_W-1:0];
                    r_rem   <= '0;
                    r_bit   <= 3'(lpht_pkg::REM_W - 1);
                    r_state <= S_HASH_B;
                end

                S_HASH_B: begin
                    if (r_bit == '0) begin
                        // home slot, below the effective size
                        r_addr  <= h_next[lpht_pkg::AW-1:0];
                        r_left  <= r_size;
                        r_state <= S_SCAN;
                    end else begin
                        r_rem <= h_next[lpht_pkg::REM_W-1:0];
                        r_bit <= r_bit - 3'd1;
                    end
                end

                S_SCAN: begin
                    if (r_ev_v && ev_hit) begin
                        // evaluate side: slot hits (query: busy with the key; insert: free or holding the key)
                        r_ev_v     <= 1'b0;
                        r_left     <= '0;
                        r_res_slot <= r_ev_addr;
                        if (r_func == lpht_pkg::FUNC_QUERY) begin
                            r_res_status <= lpht_pkg::ST_FOUND;
                            r_res_cnt    <= ev_cnt;
                        end else begin
                            r_res_status       <= r_ev_busy ? lpht_pkg::ST_ADDED
                                                            : lpht_pkg::ST_NEW;
                            r_res_cnt          <= new_cnt;
                            r_busy[r_ev_addr]  <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else if (r_ev_v && r_ev_last) begin
                        // one full lap without a hit
                        r_ev_v       <= 1'b0;
                        r_left       <= '0;
                        r_res_slot   <= '0;
                        r_res_cnt    <= '0;
                        r_res_status <= (r_func == lpht_pkg::FUNC_QUERY) ? lpht_pkg::ST_ABSENT
                                                                         : lpht_pkg::ST_FULL;
                        r_state      <= S_DONE;
                    end else if (rd_en) begin
                        // issue side: one slot read per cycle
                        r_ev_v    <= 1'b1;
                        r_ev_last <= (r_left == lpht_pkg::SIZE_W'(1));
                        r_ev_busy <= r_busy[r_addr];
                        r_ev_addr <= r_addr;
                        r_addr    <= n_addr;
                        r_left    <= r_left - lpht_pkg::SIZE_W'(1);
                    end else begin
                        r_ev_v <= 1'b0;
                    end
                end

                S_DONE: begin
                    if (out_free) begin
                        r_out_status <= r_res_status;
                        r_out_slot   <= lpht_pkg::SLOT_W'(r_res_slot);
                        r_out_cnt    <= r_res_cnt;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a pending evaluation only exists while scanning
    `LPHT_ASSERT_NOW(a_ev_in_scan, r_ev_v, r_state == S_SCAN, "evaluation outside scan")

    // a miss result carries neither slot nor count
    `LPHT_ASSERT_NOW(a_miss_zero,
        o_out_valid && (o_status == lpht_pkg::ST_FULL || o_status == lpht_pkg::ST_ABSENT),
        o_slot == '0 && o_items_at_key == '0, "miss result with slot or count")

    // an insert that lands on a slot leaves that slot busy
    `LPHT_ASSERT_NEXT(a_busy_set, wr_en, r_busy[r_res_slot], "inserted slot not busy")

    // an accepted item always leaves idle
    `LPHT_ASSERT_NEXT(a_leave_idle, in_acc, r_state != S_IDLE, "accepted item not started")

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    // cycles with nothing accepted on either channel before the run is called hung
    localparam int HANG_LIMIT   = 2000;
    // worst item: the hashing states, a full lap of 64 probes and the output handshake
    localparam int SETTLE_CYCLES = 120;
    localparam int KEY_POOL     = 48;
    localparam int RANDOM_PHASES = 12;
    localparam int OPS_PER_PHASE = 105;

    typedef struct packed {
        logic                       func;
        logic [lpht_pkg::KEY_W-1:0] key;
    } t_op;

    typedef struct packed {
        logic [lpht_pkg::STATUS_W-1:0] status;
        logic [lpht_pkg::SLOT_W-1:0]   slot;
        logic [lpht_pkg::CNT_W-1:0]    items;
    } t_outcome;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // block inputs, all known from time zero
    logic                          in_valid  = 1'b0;
    logic                          func      = lpht_pkg::FUNC_INSERT;
    logic [lpht_pkg::KEY_W-1:0]    key       = '0;
    logic                          out_stall = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [lpht_pkg::CFG_W-1:0]    cfg_data  = '0;

    // block outputs
    logic                          in_stall;
    logic                          out_valid;
    logic [lpht_pkg::STATUS_W-1:0] status;
    logic [lpht_pkg::SLOT_W-1:0]   slot;
    logic [lpht_pkg::CNT_W-1:0]    items_at_key;

    linear_probe_hash_key_table_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_func         (func),
        .i_key          (key),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_slot         (slot),
        .o_items_at_key (items_at_key),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data)
    );

    // shadow copy of the table and of table_size
    logic                       shadow_busy  [lpht_pkg::SLOTS];
    logic [lpht_pkg::KEY_W-1:0] shadow_key   [lpht_pkg::SLOTS];
    logic [lpht_pkg::CNT_W-1:0] shadow_count [lpht_pkg::SLOTS];
    logic [lpht_pkg::CFG_W-1:0] shadow_size = lpht_pkg::SIZE_RESET;

    t_op      op_q[$];       // items not yet presented to the block
    t_outcome outcome_q[$];  // results owed by the block, oldest first
    t_outcome head_outcome;
    t_op      next_op;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int fail_count     = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int hang_cycles    = 0;
    int sizes_used     = 0;
    int status_hits [5];

    logic [lpht_pkg::KEY_W-1:0] key_pool [KEY_POOL];

    // expected result of one insert or query, updating the shadow table as the block would
    function automatic t_outcome table_op_outcome(input logic op_func,
                                                  input logic [lpht_pkg::KEY_W-1:0] op_key);
        int       n;
        int       pos;
        int       steps;
        bit       hit;
        t_outcome res;
        n = int'(shadow_size);
        if (n == 0) n = 1;                                 // size zero acts as one slot
        if (n > lpht_pkg::SLOTS) n = lpht_pkg::SLOTS;      // oversize clamps to the table
        res.status = lpht_pkg::ST_ABSENT;
        res.slot   = '0;
        res.items  = '0;
        hit        = 1'b0;
        if (op_func == lpht_pkg::FUNC_QUERY) begin
            // query scans from slot 0 and takes the first busy match
            pos = 0;
            while (!hit && pos < n) begin
                if (shadow_busy[pos] && shadow_key[pos] == op_key) hit = 1'b1;
                else pos++;
            end
            if (hit) begin
                res.status = lpht_pkg::ST_FOUND;
                res.slot   = lpht_pkg::SLOT_W'(pos);
                res.items  = shadow_count[pos];
            end
        end else begin
            // insert probes linearly from the home slot, wrapping at n, one lap at most
            pos   = int'(op_key % lpht_pkg::HASH_MOD) % n;
            steps = 0;
            while (!hit && steps < n) begin
                if (!shadow_busy[pos] || shadow_key[pos] == op_key) begin
                    hit = 1'b1;
                end else begin
                    pos = (pos + 1) % n;
                    steps++;
                end
            end
            if (!hit) begin
                res.status = lpht_pkg::ST_FULL;
            end else begin
                res.status        = shadow_busy[pos] ? lpht_pkg::ST_ADDED : lpht_pkg::ST_NEW;
                shadow_busy[pos]  = 1'b1;
                shadow_key[pos]   = op_key;
                if (shadow_count[pos] != lpht_pkg::COUNT_MAX) shadow_count[pos]++;
                res.slot  = lpht_pkg::SLOT_W'(pos);
                res.items = shadow_count[pos];
            end
        end
        return res;
    endfunction

    // sender: presents queued items, idling at random between them
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                outcome_q.push_back(table_op_outcome(func, key));
                items_accepted++;
            end
            // a stalled item stays put; otherwise pick the next one or idle
            if (!in_valid || !in_stall) begin
                if (op_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_op = op_q.pop_front();
                    in_valid <= 1'b1;
                    func     <= next_op.func;
                    key      <= next_op.key;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each accepted result against the oldest one owed
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (outcome_q.size() == 0) begin
                    $error("result with no item outstanding: status %0d slot %0d items %0d",
                           status, slot, items_at_key);
                    fail_count++;
                end else begin
                    head_outcome = outcome_q.pop_front();
                    status_hits[head_outcome.status]++;
                    if (status !== head_outcome.status) begin
                        $error("status: expected %0d, got %0d", head_outcome.status, status);
                        fail_count++;
                    end
                    if (slot !== head_outcome.slot) begin
                        $error("slot: expected %0d, got %0d", head_outcome.slot, slot);
                        fail_count++;
                    end
                    if (items_at_key !== head_outcome.items) begin
                        $error("items_at_key: expected %0d, got %0d",
                               head_outcome.items, items_at_key);
                        fail_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // watchdog on handshakes
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                hang_cycles <= 0;
            end else if (hang_cycles >= HANG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                hang_cycles <= hang_cycles + 1;
            end
        end
    end

    task automatic push_op(input logic op_func, input logic [lpht_pkg::KEY_W-1:0] op_key);
        t_op op;
        op.func = op_func;
        op.key  = op_key;
        op_q.push_back(op);
    endtask

    // returns at a falling edge once the block has nothing left in flight
    task automatic wait_drained();
        while (op_q.size() != 0 || in_valid || outcome_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_table_size(input logic [lpht_pkg::CFG_W-1:0] value);
        wait_drained();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        shadow_size = value;
        sizes_used++;
        @(negedge clk);
    endtask

    initial begin
        logic [lpht_pkg::CFG_W-1:0] phase_sizes [RANDOM_PHASES];
        t_op op;
        int  pick;
        int  p;
        int  i;

        // extremes first, then shrink and grow so stale slots come back into range
        phase_sizes = '{7'd64, 7'd0, 7'd5, 7'd127, 7'd17, 7'd1,
                        7'd64, 7'd2, 7'd100, 7'd9, 7'd33, 7'd64};
        for (i = 0; i < lpht_pkg::SLOTS; i++) begin
            shadow_busy[i]  = 1'b0;
            shadow_key[i]   = '0;
            shadow_count[i] = '0;
        end
        for (i = 0; i < 5; i++) status_hits[i] = 0;
        // half arbitrary keys, half keys whose home falls in slots 0 to 9
        for (i = 0; i < KEY_POOL; i++) begin
            if (i % 2 == 0) key_pool[i] = $urandom();
            else key_pool[i] = $urandom_range(0, 40000000) * 100 + $urandom_range(0, 9);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct  = 25;
        recv_stall_pct = 57;

        // directed: reset size of 64
        push_op(lpht_pkg::FUNC_INSERT, 32'd0);             // new key at slot 0
        push_op(lpht_pkg::FUNC_INSERT, 32'hFFFF_FFFF);     // all-ones key, home 31
        push_op(lpht_pkg::FUNC_INSERT, 32'd0);             // same key again
        push_op(lpht_pkg::FUNC_INSERT, 32'd100);           // collides at home 0
        push_op(lpht_pkg::FUNC_INSERT, 32'd200);
        push_op(lpht_pkg::FUNC_INSERT, 32'd63);            // last slot
        push_op(lpht_pkg::FUNC_INSERT, 32'd163);           // home 63 busy, wraps to slot 3
        push_op(lpht_pkg::FUNC_QUERY,  32'd163);
        push_op(lpht_pkg::FUNC_QUERY,  32'hFFFF_FFFF);
        push_op(lpht_pkg::FUNC_QUERY,  32'd12345);         // not present
        push_op(lpht_pkg::FUNC_QUERY,  32'h8000_0000);

        // size zero behaves as a single slot
        write_table_size(7'd0);
        push_op(lpht_pkg::FUNC_INSERT, 32'd5);             // only slot busy with another key
        push_op(lpht_pkg::FUNC_INSERT, 32'd0);
        push_op(lpht_pkg::FUNC_QUERY,  32'd100);           // slot 1 out of range now

        // oversize clamps to 64, slot 1 visible again
        write_table_size(7'd127);
        push_op(lpht_pkg::FUNC_QUERY,  32'd100);

        // three slots, all busy
        write_table_size(7'd3);
        push_op(lpht_pkg::FUNC_INSERT, 32'd7);             // full after one lap
        push_op(lpht_pkg::FUNC_INSERT, 32'd200);           // probes to its own slot
        push_op(lpht_pkg::FUNC_INSERT, 32'd163);           // its slot 3 is beyond the table
        push_op(lpht_pkg::FUNC_QUERY,  32'd163);

        write_table_size(7'd4);
        push_op(lpht_pkg::FUNC_INSERT, 32'd163);           // home 3 holds it
        push_op(lpht_pkg::FUNC_INSERT, 32'hFFFF_FFFF);     // home 3, wraps through 0..2: full

        // count saturation takes 65535 inserts under one key, far beyond this run

        // random phases: mostly repeated and colliding keys so probes run long
        for (p = 0; p < RANDOM_PHASES; p++) begin
            write_table_size(phase_sizes[p]);
            if (p < 4) begin
                send_idle_pct  = 25;
                recv_stall_pct = 57;
            end else if (p < 8) begin
                send_idle_pct  = 57;
                recv_stall_pct = 25;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            for (i = 0; i < OPS_PER_PHASE; i++) begin
                pick    = $urandom_range(0, 99);
                op.func = ($urandom_range(0, 99) < 40) ? lpht_pkg::FUNC_QUERY
                                                       : lpht_pkg::FUNC_INSERT;
                if (pick < 70) op.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
                else if (pick < 80) op.key = $urandom_range(0, 40000000) * 100
                                             + $urandom_range(0, 3);
                else op.key = $urandom();
                op_q.push_back(op);
            end
        end

        wait_drained();
        $display("run covered %0d items and %0d results over %0d table_size writes",
                 items_accepted, results_seen, sizes_used);
        $display("  new %0d, added %0d, full %0d, found %0d, not found %0d",
                 status_hits[lpht_pkg::ST_NEW], status_hits[lpht_pkg::ST_ADDED],
                 status_hits[lpht_pkg::ST_FULL], status_hits[lpht_pkg::ST_FOUND],
                 status_hits[lpht_pkg::ST_ABSENT]);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/lpht_pkg.sv
design/linear_probe_hash_key_table_top.sv
tb/tb.sv
